### design/ldrt_pkg.sv
// Package for the longest distinct-byte run tracker.
// Holds the request/response payload structs and the default sizes.
// No dependencies.
package ldrt_pkg;

   localparam int MAX_STRING_LEN_DEF = 65536;
   localparam int ALPHABET_SIZE_DEF  = 256;
   localparam int CHAR_W             = 8;
   localparam int RUN_W              = 17;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [RUN_W-1:0] current_run;
      logic [RUN_W-1:0] longest_run;
      logic             string_done;
      logic             too_long;
   } rsp_payload_type;

endpackage

### design/longest_distinct_run_tracker.sv
// Top level of the longest distinct-byte run tracker.
// Depends on ldrt_pkg for payload types and default sizes.
//
// Takes one request per clock: a byte of a string and a last-byte flag. Each
// request gives exactly one response with the length of the distinct-byte
// window ending at that byte, the longest such window so far, a done mark on
// the last byte and a sticky too-long flag. Sustained rate is one request per
// cycle while rsp_ready stays high; a held response stalls stage 1 and so
// req_ready. The accepting edge reads the last-position table into the stage 1
// registers, and the update stage then loads the output register once it is
// free. The last-position table is a synchronous memory with one read and one
// write port; a byte repeated in back-to-back requests gets the pending write
// forwarded into the read register. Seen marks are flip-flops, cleared together
// at the end of each string, so there is no clearing pass after reset. Once a
// string reaches MAX_STRING_LEN bytes the position saturates and too_long rises
// from the next byte on.
module longest_distinct_run_tracker #(
   parameter int MAX_STRING_LEN = ldrt_pkg::MAX_STRING_LEN_DEF,
   parameter int ALPHABET_SIZE  = ldrt_pkg::ALPHABET_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ldrt_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ldrt_pkg::rsp_payload_type rsp_payload
);

   localparam int PW     = $clog2(MAX_STRING_LEN);       // position width
   localparam int RW     = $clog2(MAX_STRING_LEN + 1);   // run / window width
   localparam int AW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int CHAR_W = ldrt_pkg::CHAR_W;
   localparam int RUN_W  = ldrt_pkg::RUN_W;
   localparam int NCODES = 1 << CHAR_W;
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_STRING_LEN - 1);

   // Byte code folded into the alphabet, built at elaboration.
   function automatic logic [NCODES-1:0][AW-1:0] fold_table_f();
      logic [NCODES-1:0][AW-1:0] tbl;
      for (int i = 0; i < NCODES; i++) begin
         tbl[i] = AW'(i % ALPHABET_SIZE);
      end
      return tbl;
   endfunction

   localparam logic [NCODES-1:0][AW-1:0] FOLD_TABLE = fold_table_f();

   // ---------------------------------------------------------------
   // Stage 0: accept request, read last-position table.
   // ---------------------------------------------------------------
   logic            req_fire;
   logic [AW-1:0]   rd_addr;

   // Stage 1 registers
   logic            s1_valid_ff, s1_valid_in;
   logic [AW-1:0]   s1_code_ff;
   logic            s1_last_ff;
   logic [PW-1:0]   lp_rdata_ff;

   // String state
   logic [ALPHABET_SIZE-1:0] seen_ff, seen_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [RW-1:0]   win_ff, win_in;      // window start, one past the last repeat
   logic [RW-1:0]   best_ff, best_in;
   logic            ovf_ff, ovf_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   ldrt_pkg::rsp_payload_type rsp_payload_ff;

   logic [PW-1:0]   last_pos_mem [ALPHABET_SIZE];

   logic            s1_fire;
   logic [RW-1:0]   lp_plus1;
   logic [RW-1:0]   pos_plus1;
   logic [RW-1:0]   win_new;
   logic [RW-1:0]   run_w;
   logic [RW-1:0]   best_new;

   assign rd_addr   = FOLD_TABLE[req_payload.char_code];
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Table: write from stage 1, read for the incoming request. A write to
   // the address being read in the same edge is forwarded.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         last_pos_mem[s1_code_ff] <= pos_ff;
      end
      if (req_fire) begin
         if (s1_fire && (s1_code_ff == rd_addr)) begin
            lp_rdata_ff <= pos_ff;
         end else begin
            lp_rdata_ff <= last_pos_mem[rd_addr];
         end
         s1_code_ff <= rd_addr;
         s1_last_ff <= req_payload.end_of_string;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: window arithmetic.
   // ---------------------------------------------------------------
   assign lp_plus1  = RW'(lp_rdata_ff) + RW'(1);
   assign pos_plus1 = RW'(pos_ff) + RW'(1);

   always_comb begin
      win_new = win_ff;
      if (seen_ff[s1_code_ff] && (lp_plus1 > win_ff)) begin
         win_new = lp_plus1;
      end
      // a run is never shorter than the byte itself
      run_w    = (pos_plus1 > win_new) ? (pos_plus1 - win_new) : RW'(1);
      best_new = (run_w > best_ff) ? run_w : best_ff;
   end

   always_comb begin
      seen_in = seen_ff;
      pos_in  = pos_ff;
      win_in  = win_ff;
      best_in = best_ff;
      ovf_in  = ovf_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            seen_in = '0;
            pos_in  = '0;
            win_in  = '0;
            best_in = '0;
            ovf_in  = 1'b0;
         end else begin
            seen_in[s1_code_ff] = 1'b1;
            win_in  = win_new;
            best_in = best_new;
            if (pos_ff >= POS_LAST) begin
               pos_in = POS_LAST;
               ovf_in = 1'b1;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
         pos_ff       <= '0;
         win_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         win_ff       <= win_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
      end
   end

   // Output register, payload needs no reset.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_payload_ff.current_run <= RUN_W'(run_w);
         rsp_payload_ff.longest_run <= RUN_W'(best_new);
         rsp_payload_ff.string_done <= s1_last_ff;
         rsp_payload_ff.too_long    <= ovf_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request did not reach stage 1");

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("stage 1 result lost");

   a_run_bounds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (run_w != '0) && (best_new >= run_w))
      else $error("run out of bounds");

   a_string_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (pos_ff == '0) && (best_ff == '0) &&
                                  (seen_ff == '0) && !ovf_ff)
      else $error("string state not cleared");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (pos_ff == POS_LAST))
      else $error("overflow without saturated position");

endmodule

### verif/longest_distinct_run_tracker_tb.sv
// Self-checking testbench for longest_distinct_run_tracker: drives strings one byte
// per request and checks every response against an in-bench window predictor.
// Depends on ldrt_pkg for the payload structs and default sizes.
module longest_distinct_run_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Instance sizes are the package defaults, so the block is checked as shipped.
   localparam int MAX_LEN = ldrt_pkg::MAX_STRING_LEN_DEF;
   localparam int ALPHA   = ldrt_pkg::ALPHABET_SIZE_DEF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   ldrt_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   ldrt_pkg::rsp_payload_type rsp_payload;

   longest_distinct_run_tracker #(
      .MAX_STRING_LEN(MAX_LEN),
      .ALPHABET_SIZE (ALPHA)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Window predictor. Mirrors the block's per-string state at its own widths:
   // a seen bit and last position per byte value, the current byte position,
   // one past the last repeat inside the window, the best run and the sticky
   // overflow bit.
   // ---------------------------------------------------------------------------
   bit        seen_byte[ALPHA];
   bit [15:0] last_seen_at[ALPHA];
   bit [15:0] cur_pos;
   bit [16:0] win_start;
   bit [16:0] best_run;
   bit        past_limit;

   ldrt_pkg::rsp_payload_type pending_runs[$];   // responses still owed, oldest first
   int                        mismatch_count;
   int                        requests_sent;

   function automatic void clear_string();
      foreach (seen_byte[i]) seen_byte[i] = 1'b0;
      cur_pos    = '0;
      win_start  = '0;
      best_run   = '0;
      past_limit = 1'b0;
   endfunction

   function automatic ldrt_pkg::rsp_payload_type advance_window(
      ldrt_pkg::req_payload_type rq);
      ldrt_pkg::rsp_payload_type r;
      int unsigned     idx;
      bit [16:0]       pos_next;
      bit [16:0]       prev_next;
      bit [16:0]       run;
      idx       = rq.char_code % ALPHA;
      pos_next  = {1'b0, cur_pos} + 17'd1;
      prev_next = {1'b0, last_seen_at[idx]} + 17'd1;
      // A repeat only pulls the window start forward, never back (the "abba" case).
      if (seen_byte[idx] && prev_next > win_start)
         win_start = prev_next;
      last_seen_at[idx] = cur_pos;
      seen_byte[idx]    = 1'b1;
      run = (pos_next > win_start) ? pos_next - win_start : 17'd0;
      // Once the position is saturated a repeat can push the start past it.
      if (run == 0)
         run = 17'd1;
      if (run > best_run)
         best_run = run;
      r.current_run = run;
      r.longest_run = best_run;
      r.string_done = rq.end_of_string;
      r.too_long    = past_limit;   // flag as it stood before this byte
      if (rq.end_of_string) begin
         clear_string();
      end else if (cur_pos >= MAX_LEN - 1) begin
         cur_pos    = 16'(MAX_LEN - 1);
         past_limit = 1'b1;
      end else begin
         cur_pos = cur_pos + 16'd1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: ready follows a repeating stall pattern; each accepted
   // response is compared with the oldest owed one.
   // ---------------------------------------------------------------------------
   int unsigned stall_period;   // 0 = always ready
   int unsigned stall_len;      // stalled cycles at the start of each period
   int unsigned ready_tick;

   always @(negedge clock) begin
      ready_tick <= ready_tick + 1;
      rsp_ready  <= (stall_period == 0) || ((ready_tick % stall_period) >= stall_len);
   end

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : response_check
      ldrt_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_runs.size() == 0) begin
            $error("response with none owed: current_run %0d, longest_run %0d",
                   rsp_payload.current_run, rsp_payload.longest_run);
            mismatch_count++;
         end else begin
            want = pending_runs.pop_front();
            check_field("current_run", 32'(want.current_run),
                        32'(rsp_payload.current_run));
            check_field("longest_run", 32'(want.longest_run),
                        32'(rsp_payload.longest_run));
            check_field("string_done", 32'(want.string_done),
                        32'(rsp_payload.string_done));
            check_field("too_long", 32'(want.too_long), 32'(rsp_payload.too_long));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side. Bursts of burst_max requests at most, then up to gap_max idle
   // cycles; gap_max of 0 streams one request per cycle while req_ready is high.
   // ---------------------------------------------------------------------------
   int unsigned burst_max = 1;
   int unsigned gap_max;
   int unsigned burst_left = 1;

   task automatic set_sender(int unsigned bmax, int unsigned gmax);
      burst_max  = bmax;
      gap_max    = gmax;
      burst_left = $urandom_range(1, bmax);
   endtask

   task automatic set_receiver(int unsigned period, int unsigned len);
      stall_period = period;
      stall_len    = len;
   endtask

   // Random receiver: a quarter of the time always ready, else a short pattern.
   task automatic shuffle_receiver();
      int unsigned p;
      if ($urandom_range(0, 3) == 0) begin
         set_receiver(0, 0);
      end else begin
         p = $urandom_range(2, 7);
         set_receiver(p, $urandom_range(1, p - 1));
      end
   endtask

   task automatic send_byte(input bit [7:0] code, input bit last);
      ldrt_pkg::req_payload_type pl;
      int unsigned     gap;
      pl.char_code     = code;
      pl.end_of_string = last;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= pl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_runs.push_back(advance_window(pl));
      requests_sent++;
      // Valid stays up inside a burst; a gap lowers it on the next falling edge.
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, burst_max);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Bytes drawn from span values starting at base, wrapping around 255.
   task automatic send_string(int unsigned len, bit [7:0] base, int unsigned span);
      for (int unsigned i = 0; i < len; i++)
         send_byte(8'(base + $urandom_range(0, span - 1)), i == len - 1);
   endtask

   // Drop valid so no request is repeated, then wait for every owed response.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Byte extremes, one-byte strings, classic puzzle strings, and "abba" where a
   // repeat falls before the current window start.
   task automatic test_directed();
      string words[3] = '{"abcabcbb", "pwwkew", "abba"};
      bit [7:0] edges[5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00};
      set_sender(4, 2);
      set_receiver(3, 1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      foreach (words[w])
         for (int i = 0; i < words[w].len(); i++)
            send_byte(words[w][i], i == words[w].len() - 1);
      foreach (edges[i])
         send_byte(edges[i], i == 4);
   endtask

   // Tiny alphabets, first at full rate so repeats land on consecutive cycles
   // and exercise the table write-to-read forwarding, then with a stalling receiver.
   task automatic test_back_to_back_repeats();
      set_sender(1, 0);
      set_receiver(0, 0);
      for (int s = 0; s < 12; s++)
         send_string($urandom_range(2, 12), 8'($urandom), $urandom_range(1, 3));
      set_receiver(2, 1);
      for (int s = 0; s < 6; s++)
         send_string($urandom_range(2, 12), 8'($urandom), $urandom_range(1, 3));
   endtask

   // Hold responses back so the pipeline fills, pause mid-string until every
   // owed response has come, then finish the string.
   task automatic test_pause_mid_string();
      set_sender(8, 0);
      set_receiver(9, 6);
      for (int i = 0; i < 12; i++)
         send_byte(8'($urandom_range(0, 7)), 1'b0);
      drain_responses();
      set_receiver(0, 0);
      send_string(12, 8'h00, 8);
      drain_responses();
   endtask

   // Strings that use every byte value once, so the run climbs to 256,
   // followed by a tail of repeats.
   task automatic test_full_alphabet();
      bit [7:0]    perm[256];
      bit [7:0]    t;
      int unsigned j;
      for (int k = 0; k < 2; k++) begin
         foreach (perm[i]) perm[i] = 8'(i);
         for (int i = 255; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
         end
         set_sender($urandom_range(4, 16), $urandom_range(0, 3));
         shuffle_receiver();
         foreach (perm[i])
            send_byte(perm[i], 1'b0);
         send_string(20, 8'($urandom), 256);
      end
   endtask

   // Mostly short strings over random alphabets, often small, some long ones and
   // some one-byte ones, with sender and receiver pacing changed per string.
   task automatic test_random_strings();
      int unsigned stop_at;
      int unsigned len;
      int unsigned span;
      int unsigned pick;
      stop_at = requests_sent + 550;
      while (requests_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            len = 1;
         else if (pick < 20)
            len = $urandom_range(41, 300);
         else
            len = $urandom_range(2, 40);
         span = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16) : $urandom_range(1, 256);
         set_sender($urandom_range(1, 8), $urandom_range(0, 6));
         shuffle_receiver();
         send_string(len, 8'($urandom), span);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      foreach (last_seen_at[i]) last_seen_at[i] = '0;
      clear_string();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_to_back_repeats();
      test_pause_mid_string();
      test_full_alphabet();
      test_random_strings();

      @(negedge clock);
      req_valid <= 1'b0;
      set_receiver(3, 1);
      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Run limit: ends the run as failed if the sequence has not finished first.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
